[hw/rtl/gtpe_pkg.sv]
// ----------------------------------------------------------------------------
// gtpe_pkg
// Shared types and constants for the GF(2^8) triple parity encoder
// ----------------------------------------------------------------------------
package gtpe_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned LANE_W    = 8;
  localparam int unsigned MAX_LANES = WORD_W / LANE_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [LANE_W-1:0] lane_t;

  // reduction polynomial after reset (x^8 + x^4 + x^3 + x^2 + 1)
  localparam lane_t POLY_RESET = 8'h1d;

  typedef struct packed {
    word_t data_word;
    logic  first_block;
    logic  last_block;
  } item_t;

  typedef struct packed {
    word_t p_word;
    word_t q_word;
    word_t r_word;
  } result_t;

endpackage

[hw/rtl/gtpe_in_if.sv]
// ----------------------------------------------------------------------------
// gtpe_in_if
// Data word channel: valid/ready with one column word per transaction
// ----------------------------------------------------------------------------
interface gtpe_in_if;
  logic            valid;
  logic            ready;
  gtpe_pkg::word_t data_word;
  logic            first_block;
  logic            last_block;

  modport source (output valid, output data_word, output first_block,
                  output last_block, input ready);
  modport sink   (input valid, input data_word, input first_block,
                  input last_block, output ready);
endinterface

[hw/rtl/gtpe_out_if.sv]
// ----------------------------------------------------------------------------
// gtpe_out_if
// Parity result channel: valid/ready with P, Q and R per transaction
// ----------------------------------------------------------------------------
interface gtpe_out_if;
  logic            valid;
  logic            ready;
  gtpe_pkg::word_t p_word;
  gtpe_pkg::word_t q_word;
  gtpe_pkg::word_t r_word;

  modport source (output valid, output p_word, output q_word, output r_word,
                  input ready);
  modport sink   (input valid, input p_word, input q_word, input r_word,
                  output ready);
endinterface

[hw/rtl/gtpe_cfg_if.sv]
// ----------------------------------------------------------------------------
// gtpe_cfg_if
// Configuration write channel for the field polynomial register
// ----------------------------------------------------------------------------
interface gtpe_cfg_if;
  logic            valid;
  logic            ready;
  gtpe_pkg::lane_t field_polynomial;

  modport source (output valid, output field_polynomial, input ready);
  modport sink   (input valid, input field_polynomial, output ready);
endinterface

[hw/rtl/gtpe_in_stage.sv]
// ----------------------------------------------------------------------------
// gtpe_in_stage
// Input register holding one data word until the accumulators consume it
// ----------------------------------------------------------------------------
module gtpe_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  gtpe_pkg::item_t in_item,
  output logic            in_ready,
  input  logic            take,
  output logic            hold_valid,
  output gtpe_pkg::item_t hold_item
);

  logic            valid_r;
  gtpe_pkg::item_t item_r;

  // free when empty or when the held word leaves this cycle
  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

[hw/rtl/gtpe_accum.sv]
// ----------------------------------------------------------------------------
// gtpe_accum
// P/Q/R accumulators with lane-wise GF(2^8) update and result register
// ----------------------------------------------------------------------------
module gtpe_accum #(
  parameter int unsigned BYTE_LANES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gtpe_pkg::lane_t   poly,
  input  logic              hold_valid,
  input  gtpe_pkg::item_t   hold_item,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output gtpe_pkg::result_t out_result
);

  gtpe_pkg::word_t   p_r, q_r, r_r;
  gtpe_pkg::word_t   p_nxt, q_nxt, r_nxt;
  gtpe_pkg::word_t   data_m;
  gtpe_pkg::result_t res_r;
  logic              out_valid_r;
  logic              out_free;

  // multiply every active lane by two; inactive lanes read as zero
  function automatic gtpe_pkg::word_t mul2(input gtpe_pkg::word_t x,
                                           input gtpe_pkg::lane_t p);
    gtpe_pkg::word_t res;
    gtpe_pkg::lane_t b;
    res = '0;
    for (int k = 0; k < int'(gtpe_pkg::MAX_LANES); k++) begin
      b = x[k*gtpe_pkg::LANE_W +: gtpe_pkg::LANE_W];
      if (k < int'(BYTE_LANES)) begin
        res[k*gtpe_pkg::LANE_W +: gtpe_pkg::LANE_W] =
          {b[gtpe_pkg::LANE_W-2:0], 1'b0} ^ (b[gtpe_pkg::LANE_W-1] ? p : '0);
      end
    end
    return res;
  endfunction

  function automatic gtpe_pkg::word_t lane_mask();
    gtpe_pkg::word_t m;
    m = '0;
    for (int k = 0; k < int'(gtpe_pkg::MAX_LANES); k++) begin
      if (k < int'(BYTE_LANES)) begin
        m[k*gtpe_pkg::LANE_W +: gtpe_pkg::LANE_W] = '1;
      end
    end
    return m;
  endfunction

  assign out_free = !out_valid_r || out_ready;
  // a closing word waits for the result register to be free
  assign take     = hold_valid && (!hold_item.last_block || out_free);

  assign data_m = hold_item.data_word & lane_mask();

  always_comb begin
    if (hold_item.first_block) begin
      p_nxt = data_m;
      q_nxt = data_m;
      r_nxt = data_m;
    end else begin
      p_nxt = p_r ^ data_m;
      q_nxt = mul2(q_r, poly) ^ data_m;
      r_nxt = mul2(mul2(r_r, poly), poly) ^ data_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
      q_r <= '0;
      r_r <= '0;
    end else if (take) begin
      p_r <= p_nxt;
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && hold_item.last_block) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hold_item.last_block) begin
      res_r.p_word <= p_nxt;
      res_r.q_word <= q_nxt;
      res_r.r_word <= r_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = res_r;

endmodule

[hw/rtl/gf256_triple_parity_encoder_core.sv]
// ----------------------------------------------------------------------------
// gf256_triple_parity_encoder_core
// Streaming P/Q/R parity encoder over GF(2^8) byte lanes
// ----------------------------------------------------------------------------
// The core takes one 64-bit column word per clock and keeps three running
// parities: P (plain xor), Q (Horner sum with multiplier 2) and R (Horner
// sum with multiplier 4), each computed per byte lane in GF(2^8) under the
// polynomial held in the configuration register (0x1d after reset). A word
// flagged first_block restarts the column, a word flagged last_block closes
// it and produces one result transaction with P, Q and R. Sustained rate is
// one word per cycle unless a closing word waits for a busy result register;
// the accumulator update is a loop of shift and xor logic. A result reaches
// the output through the input register, then the result register. The input
// stays ready while a result waits, so long as that waiting result is not
// blocking a second closing word. Lanes at or above BYTE_LANES are ignored on
// input and read as zero on output. Polynomial writes are always accepted and
// should only be issued while no column is in flight.
// ----------------------------------------------------------------------------
module gf256_triple_parity_encoder_core #(
  parameter int unsigned BYTE_LANES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  gtpe_in_if.sink    in_chan,
  gtpe_out_if.source out_chan,
  gtpe_cfg_if.sink   cfg_chan
);

  // configuration: reduction polynomial, low eight bits
  gtpe_pkg::lane_t   poly_r;

  // input register to accumulator handoff
  gtpe_pkg::item_t   in_item;
  gtpe_pkg::item_t   hold_item;
  logic              hold_valid;
  logic              take;

  // result register
  gtpe_pkg::result_t result;
  logic              result_valid;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= gtpe_pkg::POLY_RESET;
    end else if (cfg_chan.valid) begin
      poly_r <= cfg_chan.field_polynomial;
    end
  end

  // pack the incoming transaction
  assign in_item.data_word   = in_chan.data_word;
  assign in_item.first_block = in_chan.first_block;
  assign in_item.last_block  = in_chan.last_block;

  gtpe_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_item    (in_item),
    .in_ready   (in_chan.ready),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // accumulators plus result register; intermediate words never stall
  gtpe_accum #(
    .BYTE_LANES (BYTE_LANES)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .poly       (poly_r),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (take),
    .out_valid  (result_valid),
    .out_ready  (out_chan.ready),
    .out_result (result)
  );

  assign out_chan.valid  = result_valid;
  assign out_chan.p_word = result.p_word;
  assign out_chan.q_word = result.q_word;
  assign out_chan.r_word = result.r_word;

endmodule

[bench/parity_check_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// parity_check_pkg
// Column parity predictor and result scoreboard for the P/Q/R encoder bench
// ----------------------------------------------------------------------------
// Keeps its own P, Q and R running sums per byte lane and the polynomial in
// use. Every accepted column word updates them, and every closing word queues
// the parity the core must return. Results are checked in order.
// ----------------------------------------------------------------------------
package parity_check_pkg;

  import gtpe_pkg::*;

  class parity_scoreboard;
    int unsigned lanes;
    lane_t       poly;
    word_t       p_sum;
    word_t       q_sum;
    word_t       r_sum;
    result_t     pending[$];
    int unsigned errors;
    int unsigned checked;

    function new(int unsigned lane_count);
      lanes   = lane_count;
      poly    = POLY_RESET;
      p_sum   = '0;
      q_sum   = '0;
      r_sum   = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_poly(lane_t value);
      poly = value;
    endfunction

    function word_t live_lanes();
      word_t m;
      m = '0;
      for (int k = 0; k < MAX_LANES; k++)
        if (k < lanes) m[k*LANE_W +: LANE_W] = '1;
      return m;
    endfunction

    // per-lane multiply by x in GF(2^8)
    function word_t gf_double(word_t x);
      word_t y;
      lane_t b;
      y = '0;
      for (int k = 0; k < MAX_LANES; k++) begin
        if (k < lanes) begin
          b = x[k*LANE_W +: LANE_W];
          y[k*LANE_W +: LANE_W] = {b[LANE_W-2:0], 1'b0} ^ (b[LANE_W-1] ? poly : lane_t'(0));
        end
      end
      return y;
    endfunction

    function void note_word(word_t data, logic first, logic last);
      word_t   d;
      result_t exp;
      d = data & live_lanes();
      if (first) begin
        p_sum = d;
        q_sum = d;
        r_sum = d;
      end else begin
        p_sum = p_sum ^ d;
        q_sum = gf_double(q_sum) ^ d;
        r_sum = gf_double(gf_double(r_sum)) ^ d;
      end
      if (last) begin
        exp.p_word = p_sum;
        exp.q_word = q_sum;
        exp.r_word = r_sum;
        pending.push_back(exp);
      end
    endfunction

    function void check_result(word_t p, word_t q, word_t r);
      result_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected parity result p=%h q=%h r=%h", p, q, r);
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (p !== exp.p_word || q !== exp.q_word || r !== exp.r_word) begin
        errors++;
        if (errors <= 10) begin
          $display("parity mismatch on result %0d", checked);
          $display("  p expected %h got %h", exp.p_word, p);
          $display("  q expected %h got %h", exp.q_word, q);
          $display("  r expected %h got %h", exp.r_word, r);
        end
      end
    endfunction

    function bit clean();
      if (pending.size() != 0)
        $display("%0d parity results never arrived", pending.size());
      return errors == 0 && pending.size() == 0;
    endfunction
  endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GF(2^8) triple parity encoder core
// ----------------------------------------------------------------------------
// Streams column words into the core with bursty valid and a patterned
// result stall, predicts P, Q and R per byte lane, and checks each result
// transaction in order. Runs a short directed set under the reset polynomial,
// then random columns and malformed sequences under several polynomials.
// ----------------------------------------------------------------------------
module tb_top;

  import gtpe_pkg::*;
  import parity_check_pkg::*;

  localparam int unsigned LANES          = 8;
  localparam int unsigned PHASE_WORDS    = 320;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;

  gtpe_in_if  in_if ();
  gtpe_out_if out_if ();
  gtpe_cfg_if cfg_if ();

  gf256_triple_parity_encoder_core #(
    .BYTE_LANES (LANES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  parity_scoreboard sb;

  int unsigned burst_left;
  int unsigned words_sent;
  int unsigned poly_settings;
  int unsigned idle_cycles;
  bit          sending;
  bit          col_closed;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitors: every accepted transaction goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready)
        sb.set_poly(cfg_if.field_polynomial);
      if (in_if.valid && in_if.ready)
        sb.note_word(in_if.data_word, in_if.first_block, in_if.last_block);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.p_word, out_if.q_word, out_if.r_word);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side stall pattern: segments of fixed period and random stall duty
  initial begin
    int unsigned seg_left;
    int unsigned period;
    int unsigned duty;
    int unsigned phase;
    seg_left     = 0;
    period       = 1;
    duty         = 0;
    phase        = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        seg_left = $urandom_range(50, 400);
        period   = $urandom_range(1, 16);
        duty     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, period - 1);
        phase    = 0;
      end
      out_if.ready <= (phase >= duty);
      phase = (phase + 1 == period) ? 0 : phase + 1;
      seg_left--;
    end
  end

  function automatic word_t random_word();
    word_t w;
    case ($urandom_range(0, 7))
      0: w = '1;
      1: w = '0;
      2: w = {MAX_LANES{8'h80}};
      3: begin
        for (int k = 0; k < MAX_LANES; k++) begin
          case ($urandom_range(0, 3))
            0: w[k*LANE_W +: LANE_W] = 8'h00;
            1: w[k*LANE_W +: LANE_W] = 8'hff;
            2: w[k*LANE_W +: LANE_W] = 8'h80;
            default: w[k*LANE_W +: LANE_W] = lane_t'($urandom);
          endcase
        end
      end
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic drop_valid();
    if (sending) begin
      in_if.valid <= 1'b0;
      sending = 1'b0;
    end
  endtask

  // one column word, with a random gap between bursts
  task automatic push_word(input word_t d, input logic first, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        drop_valid();
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_if.data_word   <= d;
    in_if.first_block <= first;
    in_if.last_block  <= last;
    in_if.valid       <= 1'b1;
    sending = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    col_closed = last;
  endtask

  // hold off until every queued parity result is back and the pipe is empty
  task automatic wait_drain();
    drop_valid();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_poly(input lane_t value);
    cfg_if.field_polynomial <= value;
    cfg_if.valid            <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    poly_settings++;
  endtask

  task automatic random_column();
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
    for (int unsigned i = 0; i < len; i++)
      push_word(random_word(), i == 0, i == len - 1);
  endtask

  // stray words with random framing bits
  task automatic noise_words();
    repeat ($urandom_range(1, 4))
      push_word(random_word(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    lane_t       plan[5];
    int unsigned phase_end;
    bit          paused;
    sb            = new(LANES);
    burst_left    = 0;
    words_sent    = 0;
    poly_settings = 1;
    idle_cycles   = 0;
    sending       = 1'b0;
    col_closed    = 1'b1;
    paused        = 1'b0;
    rst_n                   = 1'b0;
    in_if.valid             = 1'b0;
    in_if.data_word         = '0;
    in_if.first_block       = 1'b0;
    in_if.last_block        = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.field_polynomial = POLY_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // closing word with no opening word right after reset
    push_word(64'h0123_4567_89ab_cdef, 1'b0, 1'b1);
    // single-word columns at both extremes
    push_word('1, 1'b1, 1'b1);
    push_word('0, 1'b1, 1'b1);
    // all ones keeps every lane top bit set through the reduction
    push_word('1, 1'b1, 1'b0);
    push_word('1, 1'b0, 1'b0);
    push_word('1, 1'b0, 1'b1);
    // top bit only, then zero
    push_word({MAX_LANES{8'h80}}, 1'b1, 1'b0);
    push_word('0, 1'b0, 1'b1);
    // alternating bit patterns
    push_word({MAX_LANES{8'h55}}, 1'b1, 1'b0);
    push_word({MAX_LANES{8'haa}}, 1'b0, 1'b0);
    push_word(64'h8040_2010_0804_0201, 1'b0, 1'b1);
    // closing word that carries on from the previous column
    push_word(64'hfedc_ba98_7654_3210, 1'b0, 1'b1);
    // longer column
    for (int i = 0; i < 8; i++)
      push_word({$urandom, $urandom} | {MAX_LANES{8'h80}}, i == 0, i == 7);

    plan[0] = 8'h00;
    plan[1] = 8'hff;
    plan[2] = lane_t'($urandom_range(1, 254));
    plan[3] = 8'h87;
    plan[4] = POLY_RESET;

    foreach (plan[n]) begin
      wait_drain();
      write_poly(plan[n]);
      paused    = 1'b0;
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 99) < 85)
          random_column();
        else
          noise_words();
        // one full pause per phase, at the first closed column past halfway
        if (!paused && words_sent >= phase_end - PHASE_WORDS / 2 && col_closed) begin
          wait_drain();
          paused = 1'b1;
        end
      end
      if (!col_closed)
        push_word(random_word(), 1'($urandom_range(0, 1)), 1'b1);
    end

    wait_drain();
    $display("covered %0d column words and %0d parity results", words_sent, sb.checked);
    $display("over %0d polynomial settings with %0d byte lanes", poly_settings, LANES);
    if (sb.clean())
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[gf256_triple_parity_encoder_core.f]
hw/rtl/gtpe_pkg.sv
hw/rtl/gtpe_in_if.sv
hw/rtl/gtpe_out_if.sv
hw/rtl/gtpe_cfg_if.sv
hw/rtl/gtpe_in_stage.sv
hw/rtl/gtpe_accum.sv
hw/rtl/gf256_triple_parity_encoder_core.sv
bench/parity_check_pkg.sv
bench/tb_top.sv
